### src/u8sbc_pkg.sv
// Shared types and constants for the UTF-8 to single-byte charset transcoder.
// Used by the decoder, the table scanner and the top level; no dependencies.
`default_nettype none
package u8sbc_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 256;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_DATA = 1'b1;

   localparam logic [7:0] LEAD2_MIN  = 8'hC0;
   localparam logic [7:0] LEAD3_MIN  = 8'hE0;
   localparam logic [5:0] CONT_MASK  = 6'h3F;
   localparam logic [4:0] LEAD2_MASK = 5'h1F;
   localparam logic [3:0] LEAD3_MASK = 4'hF;

   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_ONE  = 2'd1;
   localparam logic [1:0] PEND_TWO  = 2'd2;

   localparam logic [1:0] SEQ_TWO   = 2'd2;
   localparam logic [1:0] SEQ_THREE = 2'd3;

   typedef struct packed {
      logic        valid;
      logic [15:0] code;
   } char_type;

   typedef struct packed {
      logic        en;
      logic [7:0]  index;
      logic [15:0] code;
   } table_wr_type;

endpackage
`default_nettype wire

### src/u8sbc_decode.sv
// UTF-8 sequence decoder: assembles lead and continuation bytes into code points.
// Depends on u8sbc_pkg.
`default_nettype none
module u8sbc_decode
   import u8sbc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] data_byte,
   output char_type        char_out
);

   logic [7:0] lead_ff, lead_in;
   logic [7:0] cont_ff, cont_in;
   logic [1:0] pend_ff, pend_in;
   logic [1:0] len_ff, len_in;
   logic       done;
   logic [15:0] code;

   always_comb begin
      lead_in = lead_ff;
      cont_in = cont_ff;
      pend_in = pend_ff;
      len_in  = len_ff;
      done    = 1'b0;
      code    = '0;
      case (pend_ff)
         PEND_NONE: begin
            if (data_byte < LEAD2_MIN) begin
               done = 1'b1;
               code = {8'h00, data_byte};
            end else if (data_byte < LEAD3_MIN) begin
               lead_in = data_byte;
               len_in  = SEQ_TWO;
               pend_in = PEND_ONE;
            end else begin
               lead_in = data_byte;
               len_in  = SEQ_THREE;
               pend_in = PEND_TWO;
            end
         end
         PEND_TWO: begin
            cont_in = data_byte;
            pend_in = PEND_ONE;
         end
         PEND_ONE: begin
            done    = 1'b1;
            pend_in = PEND_NONE;
            len_in  = '0;
            if (len_ff == SEQ_TWO) begin
               code = {5'b0, lead_ff[4:0] & LEAD2_MASK, data_byte[5:0] & CONT_MASK};
            end else begin
               code = {lead_ff[3:0] & LEAD3_MASK, cont_ff[5:0] & CONT_MASK,
                       data_byte[5:0] & CONT_MASK};
            end
         end
         default: begin
            pend_in = PEND_NONE;
         end
      endcase
   end

   assign char_out.valid = step && done && (code != '0);
   assign char_out.code  = code;

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff <= '0;
         cont_ff <= '0;
         pend_ff <= PEND_NONE;
         len_ff  <= '0;
      end else if (step) begin
         lead_ff <= lead_in;
         cont_ff <= cont_in;
         pend_ff <= pend_in;
         len_ff  <= len_in;
      end
   end

endmodule
`default_nettype wire

### src/u8sbc_scan.sv
// Code table memory and reverse-lookup scanner with the result register.
// Depends on u8sbc_pkg.
`default_nettype none
module u8sbc_scan
   import u8sbc_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire table_wr_type table_wr,
   input  wire char_type   char_in,
   output logic            idle,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,  // out_byte[7:0]
   output logic            rsp_tuser   // unmapped
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_HOLD
   } state_type;

   state_type         state_ff;
   logic [15:0]       mem [TABLE_DEPTH];
   logic [15:0]       rd_data_ff;
   logic [IDX_W-1:0]  addr_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic              rd_vld_ff;
   logic [15:0]       cp_ff;
   logic [IDX_W-1:0]  hit_ff;
   logic              found_ff;
   logic              rsp_valid_ff;
   logic [7:0]        rsp_byte_ff;
   logic              rsp_unmapped_ff;
   logic              out_free;

   assign idle       = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_unmapped_ff;

   always_ff @(posedge clock) begin
      if (table_wr.en) begin
         mem[table_wr.index[IDX_W-1:0]] <= table_wr.code;
      end
      rd_data_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         addr_ff      <= '0;
      end else begin
         rd_vld_ff <= 1'b0;
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (rd_vld_ff && (rd_data_ff == cp_ff)) begin
            hit_ff   <= rd_idx_ff;
            found_ff <= 1'b1;
         end
         case (state_ff)
            ST_IDLE: begin
               if (char_in.valid) begin
                  cp_ff    <= char_in.code;
                  addr_ff  <= '0;
                  found_ff <= 1'b0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               rd_idx_ff <= addr_ff;
               rd_vld_ff <= 1'b1;
               addr_ff   <= addr_ff + IDX_W'(1);
               if (addr_ff == IDX_W'(TABLE_DEPTH - 1)) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               addr_ff  <= '0;
               state_ff <= ST_HOLD;
            end
            ST_HOLD: begin
               if (out_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_byte_ff     <= found_ff ? 8'(hit_ff) : 8'h00;
                  rsp_unmapped_ff <= !found_ff;
                  state_ff        <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

### src/utf8_to_single_byte_charset_top.sv
// Top level of the UTF-8 to single-byte charset transcoder.
// Depends on u8sbc_pkg, u8sbc_decode and u8sbc_scan.
//
// Usage: the req channel carries commands. With req_tuser low a transfer
// loads table entry req_tdata[7:0] with code point req_tdata[23:8]; indexes
// at or beyond TABLE_DEPTH are dropped. With req_tuser high req_tdata[31:24]
// is the next UTF-8 byte. Load every entry before sending data.
// A completed non-zero character yields one rsp transfer: rsp_tdata holds the
// highest matching table index, rsp_tuser flags a code point found nowhere.
// Loads and bytes that leave a sequence open are accepted back to back. A completed
// character walks the code table memory one entry a cycle through its single
// read port, then passes the drain and hold states before the result register
// loads; req_tready stays low after the transfer until the scanner is idle
// again. A waiting result does not block loads or open bytes; if rsp_tready
// stays low the next lookup holds its result and req_tready stays low until
// the output register frees.
// Reset clears the decoder and the scanner; table contents are undefined
// until loaded and no clearing pass runs.
`default_nettype none
module utf8_to_single_byte_charset_top
   import u8sbc_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // table_index[7:0], table_code[23:8], data_byte[31:24]
   input  wire logic        req_tuser,  // cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,  // out_byte[7:0]
   output logic             rsp_tuser   // unmapped
);

   logic         accept;
   logic         idle;
   logic         step;
   table_wr_type table_wr;
   char_type     char_dec;

   assign req_tready = idle;
   assign accept     = req_tvalid && req_tready;
   assign step       = accept && (req_tuser == CMD_DATA);

   assign table_wr.en    = accept && (req_tuser == CMD_LOAD)
                           && ({1'b0, req_tdata[7:0]} < 9'(TABLE_DEPTH));
   assign table_wr.index = req_tdata[7:0];
   assign table_wr.code  = req_tdata[23:8];

   u8sbc_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (req_tdata[31:24]),
      .char_out  (char_dec)
   );

   u8sbc_scan #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .table_wr   (table_wr),
      .char_in    (char_dec),
      .idle       (idle),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

### tb/u8sbc_lookup_check.sv
// Channel monitor for the UTF-8 to single-byte charset transcoder: decodes accepted
// req transfers, predicts each translated byte and compares it with the rsp side.
// Depends on u8sbc_pkg.
module u8sbc_lookup_check
   import u8sbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        rsp_tuser,
   output int          fail_count,
   output int          pending_chars
);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       unmapped;
   } char_out_type;

   logic [15:0]  known_codes [TABLE_DEPTH_DEFAULT];
   logic [7:0]   lead_q;
   logic [7:0]   cont_q;
   logic [1:0]   bytes_left;
   logic [1:0]   seq_len;
   char_out_type expected_chars [$];
   int           results_seen;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on %s at result %0d: got %0h, expected %0h",
               what, results_seen, got, want);
      fail_count++;
   endtask

   function automatic void translate_code_point(input logic [15:0] cp);
      char_out_type ch;
      logic [7:0]   hit;
      logic         found;
      hit = 8'h00;
      found = 1'b0;
      if (cp == 16'h0000) return;
      for (int i = 0; i < TABLE_DEPTH_DEFAULT; i++) begin
         if (known_codes[i[7:0]] === cp) begin
            hit = i[7:0];
            found = 1'b1;
         end
      end
      ch.out_byte = found ? hit : 8'h00;
      ch.unmapped = !found;
      expected_chars.insert(expected_chars.size(), ch);
   endfunction

   task automatic predict_transfer(input logic user, input logic [31:0] data);
      logic [7:0]  idx;
      logic [7:0]  b;
      logic [15:0] cp;
      idx = data[7:0];
      b = data[31:24];
      if (user == CMD_LOAD) begin
         known_codes[idx] = data[23:8];
      end else if (bytes_left == PEND_NONE) begin
         if (b < LEAD2_MIN) begin
            translate_code_point({8'h00, b});
         end else begin
            lead_q = b;
            if (b < LEAD3_MIN) begin
               seq_len = SEQ_TWO;
               bytes_left = PEND_ONE;
            end else begin
               seq_len = SEQ_THREE;
               bytes_left = PEND_TWO;
            end
         end
      end else if (bytes_left == PEND_TWO) begin
         cont_q = b;
         bytes_left = PEND_ONE;
      end else begin
         bytes_left = PEND_NONE;
         if (seq_len == SEQ_TWO)
            cp = {5'b00000, lead_q[4:0] & LEAD2_MASK, b[5:0] & CONT_MASK};
         else
            cp = {lead_q[3:0] & LEAD3_MASK, cont_q[5:0] & CONT_MASK, b[5:0] & CONT_MASK};
         translate_code_point(cp);
      end
   endtask

   task automatic check_result();
      char_out_type want;
      if (expected_chars.size() == 0) begin
         report_mismatch("unexpected result", 32'(rsp_tdata), 0);
      end else begin
         want = expected_chars.pop_front();
         if (rsp_tdata !== want.out_byte)
            report_mismatch("out_byte", 32'(rsp_tdata), 32'(want.out_byte));
         if (rsp_tuser !== want.unmapped)
            report_mismatch("unmapped", 32'(rsp_tuser), 32'(want.unmapped));
      end
      results_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         lead_q = 8'h00;
         cont_q = 8'h00;
         bytes_left = PEND_NONE;
         seq_len = 2'd0;
         expected_chars.delete();
         fail_count = 0;
         results_seen = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (req_tvalid && req_tready) predict_transfer(req_tuser, req_tdata);
      end
      pending_chars <= expected_chars.size();
   end

endmodule

### tb/tb_utf8_to_single_byte_charset_top.sv
// Testbench top for the UTF-8 to single-byte charset transcoder: loads the code table,
// streams directed and random UTF-8 text with random idling, and gives the verdict.
// Depends on u8sbc_pkg, utf8_to_single_byte_charset_top and u8sbc_lookup_check.
module tb_utf8_to_single_byte_charset_top;
   import u8sbc_pkg::*;

   localparam int RANDOM_ITEMS   = 320;
   localparam int HOLD_CYCLES    = 1500;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int POOL_SIZE      = 48;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = 32'h0;  // table_index[7:0], table_code[23:8], data_byte[31:24]
   logic        req_tuser = 1'b0;   // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;          // out_byte[7:0]
   logic        rsp_tuser;          // unmapped
   int          fail_count;
   int          pending_chars;

   logic        hold_request = 1'b0;
   logic        steady_phase = 1'b0;
   int          items_sent = 0;
   int          stalled_cycles = 0;
   logic [15:0] loaded_codes [TABLE_DEPTH_DEFAULT];
   logic [15:0] code_pool [POOL_SIZE];

   always #4 clock = ~clock;

   utf8_to_single_byte_charset_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   u8sbc_lookup_check u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_chars (pending_chars)
   );

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result side: random back-pressure, one long hold on request
   initial begin : rsp_side
      int span;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (!steady_phase && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            span = $urandom_range(1, 11);
            repeat (span) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            span = $urandom_range(1, 30);
            repeat (span) @(posedge clock);
         end
      end
   end

   task automatic offer(input logic user, input logic [31:0] data);
      int span;
      if (!steady_phase && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         span = $urandom_range(1, 11);
         repeat (span) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= user;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic load_entry(input logic [7:0] idx, input logic [15:0] code);
      int junk;
      junk = $urandom;
      loaded_codes[idx] = code;
      offer(CMD_LOAD, {junk[7:0], code, idx});
   endtask

   task automatic feed_byte(input logic [7:0] b);
      int junk;
      junk = $urandom;
      offer(CMD_DATA, {b, junk[23:0]});
   endtask

   task automatic load_random();
      logic [15:0] code;
      code = $urandom_range(0, 1) ? code_pool[6'($urandom_range(0, POOL_SIZE - 1))]
                                  : 16'($urandom_range(0, 65535));
      load_entry(8'($urandom_range(0, 255)), code);
   endtask

   task automatic maybe_load();
      if ($urandom_range(0, 9) == 0) load_random();
   endtask

   // continuation top bits and the spare lead bit are random: the block ignores them
   task automatic send_char(input logic [15:0] cp, input int nbytes);
      int r;
      r = $urandom;
      case (nbytes)
         1: feed_byte(cp[7:0]);
         2: begin
            feed_byte({3'b110, cp[10:6]});
            maybe_load();
            feed_byte({r[1:0], cp[5:0]});
         end
         default: begin
            feed_byte({3'b111, r[2], cp[15:12]});
            maybe_load();
            feed_byte({r[4:3], cp[11:6]});
            maybe_load();
            feed_byte({r[6:5], cp[5:0]});
         end
      endcase
   endtask

   function automatic int pick_length(input logic [15:0] cp);
      int shortest;
      shortest = (cp < 16'h00C0) ? 1 : ((cp < 16'h0800) ? 2 : 3);
      if ($urandom_range(0, 4) == 0) return $urandom_range(shortest, 3);
      return shortest;
   endfunction

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_chars != 0) @(posedge clock);
   endtask

   initial begin : req_side
      int          base;
      int          pick;
      int          r;
      logic [15:0] cp;
      logic        hold_done;
      logic        pause_done;
      hold_done = 1'b0;
      pause_done = 1'b0;

      code_pool[0] = 16'hFFFF;
      code_pool[1] = 16'h0080;
      code_pool[2] = 16'h07FF;
      code_pool[3] = 16'h0800;
      for (int i = 4; i < POOL_SIZE; i++)
         code_pool[i[5:0]] = 16'($urandom_range(16'h0080, 16'hFFFD));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // fill the whole table before any text
      load_entry(8'h00, 16'hFFFE);
      for (int i = 1; i < 255; i++) begin
         if (i == 8'h7F)
            load_entry(i[7:0], 16'h0000);
         else if (i < 8'h60)
            load_entry(i[7:0], i[15:0]);
         else
            load_entry(i[7:0], code_pool[6'($urandom_range(0, POOL_SIZE - 1))]);
      end
      load_entry(8'hFF, 16'hFFFF);

      feed_byte(8'h41);
      feed_byte(8'h00);
      feed_byte(8'h7F);
      feed_byte(8'h80);
      feed_byte(8'hBF);
      send_char(16'h00A9, 2);
      feed_byte(8'hC1);
      feed_byte(8'hFF);
      send_char(16'h07FF, 2);
      feed_byte(8'hEF);
      feed_byte(8'hBF);
      feed_byte(8'hBE);
      send_char(16'hFFFF, 3);
      feed_byte(8'hF0);
      feed_byte(8'h80);
      feed_byte(8'h81);
      feed_byte(8'hC0);
      feed_byte(8'h80);
      feed_byte(8'hE0);
      load_entry(8'h42, 16'h0801);
      feed_byte(8'hA0);
      feed_byte(8'h81);

      base = items_sent;
      while (items_sent - base < RANDOM_ITEMS) begin
         if (!hold_done && items_sent - base >= 80) begin
            hold_request = 1'b1;
            hold_done = 1'b1;
         end
         if (!pause_done && items_sent - base >= 160) begin
            drain_results();
            pause_done = 1'b1;
         end
         if (items_sent - base >= 260) steady_phase = 1'b1;

         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            send_char(16'($urandom_range(1, 127)), 1);
         end else if (pick < 60) begin
            cp = loaded_codes[8'($urandom_range(0, 255))];
            if (cp == 16'h0000) cp = 16'h0001;
            send_char(cp, pick_length(cp));
         end else if (pick < 75) begin
            r = $urandom_range(1, 65535);
            send_char(r[15:0], pick_length(r[15:0]));
         end else if (pick < 80) begin
            send_char(16'h0000, $urandom_range(1, 3));
         end else if (pick < 92) begin
            feed_byte(8'($urandom_range(0, 255)));
         end else begin
            load_random();
         end
      end

      drain_results();
      repeat (TABLE_DEPTH_DEFAULT + 40) @(posedge clock);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### utf8_to_single_byte_charset_top.f
src/u8sbc_pkg.sv
src/u8sbc_decode.sv
src/u8sbc_scan.sv
src/utf8_to_single_byte_charset_top.sv
tb/u8sbc_lookup_check.sv
tb/tb_utf8_to_single_byte_charset_top.sv
